// ----- rtl/lpde_pkg.sv -----
// ----------------------------------------------------------------------------
// LED pixel duty encoder package
// Shared widths, codes and item types for the pixel duty encoder.
// ----------------------------------------------------------------------------
package lpde_pkg;

   // Field widths.
   localparam int CHAN_W      = 8;
   localparam int PIXEL_BITS  = 24;
   localparam int DUTY_W      = 16;
   localparam int BIT_CNT_W   = $clog2(PIXEL_BITS + 1);
   localparam int CSR_INDEX_W = 1;

   // Command codes on the request channel.
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_EOF   = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_BIT_DUTY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_BIT_DUTY = 1'b1;

   // Word count loaded for each kind of item.
   localparam logic [BIT_CNT_W-1:0] PIXEL_WORDS = BIT_CNT_W'(PIXEL_BITS);
   localparam logic [BIT_CNT_W-1:0] EOF_WORDS   = BIT_CNT_W'(1);

   // Registered request item.
   typedef struct packed {
      logic                  cmd;
      logic [PIXEL_BITS-1:0] grb;
      logic [CHAN_W-1:0]     brightness;
   } pixel_type;

   // Scaled item handed to the serializer.
   typedef struct packed {
      logic                  eof;
      logic [PIXEL_BITS-1:0] grb;
   } scaled_type;

endpackage

// ----- rtl/lpde_scale.sv -----
// ----------------------------------------------------------------------------
// LED pixel duty encoder channel scaler
// Scales each 8-bit color channel to floor(channel * brightness / 255).
// ----------------------------------------------------------------------------
module lpde_scale (
   input  lpde_pkg::pixel_type  pixel,
   output lpde_pkg::scaled_type scaled
);
   import lpde_pkg::*;

   localparam int NUM_CHAN = PIXEL_BITS / CHAN_W;

   // Each channel gets one 8x8 multiplier. Division by 255 uses
   // (p + (p >> 8) + 1) >> 8, which is exact for every product of two 8-bit values.
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      logic [2*CHAN_W-1:0] product;
      logic [2*CHAN_W:0]   biased;

      assign product = pixel.grb[c*CHAN_W +: CHAN_W] * pixel.brightness;
      assign biased  = {1'b0, product} + {{(CHAN_W+1){1'b0}}, product[2*CHAN_W-1:CHAN_W]}
                       + {{(2*CHAN_W){1'b0}}, 1'b1};
      assign scaled.grb[c*CHAN_W +: CHAN_W] = biased[2*CHAN_W-1:CHAN_W];
   end

   assign scaled.eof = (pixel.cmd == CMD_EOF);

endmodule

// ----- rtl/lpde_serializer.sv -----
// ----------------------------------------------------------------------------
// LED pixel duty encoder serializer
// Shifts a scaled pixel out MSB first as duty words into an output register.
// ----------------------------------------------------------------------------
module lpde_serializer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ld_valid,
   input  lpde_pkg::scaled_type         ld_item,
   output logic                         ld_ready,
   input  logic [lpde_pkg::DUTY_W-1:0]  one_duty,
   input  logic [lpde_pkg::DUTY_W-1:0]  zero_duty,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lpde_pkg::DUTY_W-1:0]  rsp_duty_word,
   output logic                         rsp_last
);
   import lpde_pkg::*;

   logic [BIT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PIXEL_BITS-1:0] word_ff, word_in;
   logic                  eof_ff, eof_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]     rsp_duty_ff, rsp_duty_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  emit;
   logic                  load;

   // The output register can take a word when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (cnt_ff != '0) && out_free;
   assign ld_ready = (cnt_ff == '0) || ((cnt_ff == EOF_WORDS) && emit);
   assign load     = ld_valid && ld_ready;

   // Shift register and word count.
   always_comb begin
      cnt_in  = cnt_ff;
      word_in = word_ff;
      eof_in  = eof_ff;
      if (emit) begin
         cnt_in  = cnt_ff - EOF_WORDS;
         word_in = {word_ff[PIXEL_BITS-2:0], 1'b0};
      end
      if (load) begin
         cnt_in  = ld_item.eof ? EOF_WORDS : PIXEL_WORDS;
         word_in = ld_item.grb;
         eof_in  = ld_item.eof;
      end
   end

   // Output register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_last_in  = (cnt_ff == EOF_WORDS);
         if (eof_ff) begin
            rsp_duty_in = '0;
         end else begin
            rsp_duty_in = word_ff[PIXEL_BITS-1] ? one_duty : zero_duty;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      eof_ff      <= eof_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty_word = rsp_duty_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/led_pixel_duty_encoder.sv -----
// The first duty word of an item passes the input register, the serializer's shift
// register and the output register on its way to rsp. A pixel item gives 24 duty words,
// one per cycle while rsp_stall is low; an end-of-frame item gives one word.
// The next item is taken into the input register while the current one shifts out.
// Reset is synchronous: it empties all stages and clears both duty registers to zero.
// ----------------------------------------------------------------------------
// LED pixel duty encoder
// Scales a GRB pixel by brightness and emits 24 timer duty words per pixel.
// ----------------------------------------------------------------------------
module led_pixel_duty_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [lpde_pkg::PIXEL_BITS-1:0]   req_pixel_grb,
   input  logic [lpde_pkg::CHAN_W-1:0]       req_brightness,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lpde_pkg::DUTY_W-1:0]       rsp_duty_word,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [lpde_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpde_pkg::DUTY_W-1:0]       csr_wdata
);
   import lpde_pkg::*;

   logic              in_valid_ff, in_valid_in;
   pixel_type         in_item_ff;
   logic              req_accept;
   logic              ser_ready;
   scaled_type        scaled;
   logic [DUTY_W-1:0] one_duty_ff, zero_duty_ff;

   // Duty registers written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= '0;
         zero_duty_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ONE_BIT_DUTY:  one_duty_ff  <= csr_wdata;
            CSR_ZERO_BIT_DUTY: zero_duty_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Input register: holds one item until the serializer takes it.
   assign req_stall  = in_valid_ff && !ser_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (ser_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.cmd        <= req_cmd;
         in_item_ff.grb        <= req_pixel_grb;
         in_item_ff.brightness <= req_brightness;
      end
   end

   // Brightness scaling between the input register and the serializer.
   lpde_scale u_scale (
      .pixel  (in_item_ff),
      .scaled (scaled)
   );

   // Bit serializer with the output register.
   lpde_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .ld_valid      (in_valid_ff),
      .ld_item       (scaled),
      .ld_ready      (ser_ready),
      .one_duty      (one_duty_ff),
      .zero_duty     (zero_duty_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_duty_word (rsp_duty_word),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/lpde_checker.sv -----
// ----------------------------------------------------------------------------
// LED pixel duty encoder checker
// Port-level assertions on the duty encoder, attached by a bind statement.
// ----------------------------------------------------------------------------
module lpde_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [lpde_pkg::DUTY_W-1:0]       rsp_duty_word,
   input logic                              rsp_last,
   input logic                              csr_wr_en,
   input logic [lpde_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [lpde_pkg::DUTY_W-1:0]       csr_wdata
);
   import lpde_pkg::*;

   logic [DUTY_W-1:0]    one_ff, zero_ff;
   logic [BIT_CNT_W-1:0] word_cnt_ff;
   logic                 rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;

   // Mirror of the duty registers as written on the port.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_ff  <= '0;
         zero_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ONE_BIT_DUTY) begin
            one_ff <= csr_wdata;
         end else begin
            zero_ff <= csr_wdata;
         end
      end
   end

   // Words delivered since the last word of the previous item.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff <= '0;
      end else if (rsp_accept) begin
         word_cnt_ff <= rsp_last ? '0 : word_cnt_ff + EOF_WORDS;
      end
   end

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty_word) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // Every duty word is a programmed code, or zero at frame end.
   a_duty_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_word == one_ff || rsp_duty_word == zero_ff ||
                    (rsp_duty_word == '0 && rsp_last))
      else $error("duty word is not a programmed code");

   // The last flag closes a frame-end word or the 24th word of a pixel.
   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_last |-> word_cnt_ff == '0 || word_cnt_ff == PIXEL_WORDS - EOF_WORDS)
      else $error("last flag at wrong word position");

   // A pixel never runs past 24 words without the last flag.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_last |-> word_cnt_ff < PIXEL_WORDS - EOF_WORDS)
      else $error("pixel emitted more than 24 words");

   // Nothing shows on the result channel right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind led_pixel_duty_encoder lpde_checker u_lpde_checker (.*);

// ----- dv/led_pixel_duty_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// LED pixel duty encoder testbench
// Sends pixel and end-of-frame items under random idling and stalls. It scales
// each color channel by brightness in integer math, predicts the 24 duty words
// per pixel (one per end of frame), and checks every word and its last flag
// in order against the block's output.
// ----------------------------------------------------------------------------
module led_pixel_duty_encoder_tb;
   import lpde_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 160;
   localparam int HOLD_AFTER  = 500;

   // One expected duty word on the output.
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              last;
   } duty_word_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_cmd        = CMD_PIXEL;
   logic [PIXEL_BITS-1:0]  req_pixel_grb  = '0;
   logic [CHAN_W-1:0]      req_brightness = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [DUTY_W-1:0]      rsp_duty_word;
   logic                   rsp_last;
   logic                   csr_wr_en      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_ONE_BIT_DUTY;
   logic [DUTY_W-1:0]      csr_wdata      = '0;

   // Local copy of the duty registers.
   logic [DUTY_W-1:0] duty_for_one  = '0;
   logic [DUTY_W-1:0] duty_for_zero = '0;

   pixel_type     pixels_to_send[$];
   duty_word_type duty_words_due[$];

   bit req_busy     = 1'b0;
   bit quiet        = 1'b0;
   bit held_once    = 1'b0;
   int send_gap     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   int words_seen   = 0;
   int idle_cycles  = 0;
   int error_count  = 0;

   led_pixel_duty_encoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_pixel_grb  (req_pixel_grb),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_duty_word  (rsp_duty_word),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Scale each channel by brightness and queue the duty words, MSB first.
   function automatic void predict_duty_words(input pixel_type item);
      logic [PIXEL_BITS-1:0] scaled;
      logic [15:0]           product;
      duty_word_type         word;
      if (item.cmd == CMD_EOF) begin
         word.duty = '0;
         word.last = 1'b1;
         duty_words_due.push_back(word);
      end else begin
         for (int c = 0; c < 3; c++) begin
            product = item.grb[c*CHAN_W +: CHAN_W] * item.brightness;
            scaled[c*CHAN_W +: CHAN_W] = CHAN_W'(product / 16'd255);
         end
         for (int k = PIXEL_BITS - 1; k >= 0; k--) begin
            word.duty = scaled[k] ? duty_for_one : duty_for_zero;
            word.last = (k == 0);
            duty_words_due.push_back(word);
         end
      end
   endfunction

   // Sender: presents the next queued item, with random gaps between items.
   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixels_to_send.size() > 0) begin
            pixel_type item;
            item = pixels_to_send.pop_front();
            req_cmd        <= item.cmd;
            req_pixel_grb  <= item.grb;
            req_brightness <= item.brightness;
            req_valid      <= 1'b1;
            req_busy = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off to back up the input.
   always @(negedge clock) begin
      if (!reset) begin
         if (!held_once && words_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 15) == 0)
               stall_left = $urandom_range(1, 17);
         end
      end
   end

   // Monitor: predicts on accepted items, checks accepted words, and watches for hangs.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_duty_words('{cmd: req_cmd, grb: req_pixel_grb,
                                 brightness: req_brightness});
            req_busy = 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            duty_word_type due;
            words_seen++;
            if (duty_words_due.size() == 0) begin
               error_count++;
               $display("%0t: duty word expected none actual %h last %b",
                        $time, rsp_duty_word, rsp_last);
            end else begin
               due = duty_words_due.pop_front();
               if (rsp_duty_word !== due.duty) begin
                  error_count++;
                  $display("%0t: duty word expected %h actual %h",
                           $time, due.duty, rsp_duty_word);
               end
               if (rsp_last !== due.last) begin
                  error_count++;
                  $display("%0t: last flag expected %b actual %b",
                           $time, due.last, rsp_last);
               end
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DUTY_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_ONE_BIT_DUTY)
         duty_for_one = value;
      else
         duty_for_zero = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_pixel(input logic cmd, input logic [PIXEL_BITS-1:0] grb,
                              input logic [CHAN_W-1:0] brightness);
      pixel_type item;
      item.cmd        = cmd;
      item.grb        = grb;
      item.brightness = brightness;
      pixels_to_send.push_back(item);
   endtask

   // Mostly pixels; brightness often sits at its extremes.
   task automatic queue_random_pixels(input int count);
      logic [CHAN_W-1:0] bright;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 5))
            0:       bright = 8'hFF;
            1:       bright = 8'h00;
            default: bright = CHAN_W'($urandom);
         endcase
         queue_pixel(($urandom_range(0, 7) == 0) ? CMD_EOF : CMD_PIXEL,
                     PIXEL_BITS'($urandom), bright);
      end
   endtask

   // Wait until every item is sent and every word has come back, then settle.
   task automatic wait_idle();
      while (pixels_to_send.size() > 0 || req_busy || duty_words_due.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both duty registers still at their reset value of zero.
      queue_pixel(CMD_PIXEL, 24'hFFFFFF, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'h0F0F0F, 8'hFF);
      queue_pixel(CMD_EOF, 24'h000000, 8'h00);
      wait_idle();

      // Directed items: field extremes, rounding edges and end of frame.
      write_csr(CSR_ONE_BIT_DUTY, 16'hFFFF);
      write_csr(CSR_ZERO_BIT_DUTY, 16'h0000);
      queue_pixel(CMD_PIXEL, 24'hFFFFFF, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'hFFFFFF, 8'h00);
      queue_pixel(CMD_PIXEL, 24'h000000, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'hFFFFFF, 8'hFE);
      queue_pixel(CMD_PIXEL, 24'h800000, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'h000001, 8'hFF);
      queue_pixel(CMD_EOF, 24'hFFFFFF, 8'hFF);
      queue_pixel(CMD_EOF, 24'h000000, 8'h00);
      queue_pixel(CMD_PIXEL, 24'hAA55AA, 8'h80);
      queue_pixel(CMD_PIXEL, 24'h55AA55, 8'h01);
      queue_pixel(CMD_PIXEL, 24'hFF00FF, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'h010101, 8'hFF);
      queue_pixel(CMD_PIXEL, 24'hFEFEFE, 8'h7F);
      queue_pixel(CMD_PIXEL, 24'hFFFFFF, 8'h01);
      queue_pixel(CMD_PIXEL, 24'h123456, 8'hAA);
      queue_pixel(CMD_EOF, 24'h5A5A5A, 8'h5A);
      wait_idle();

      // Random phases, each under its own pair of duty values.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_ONE_BIT_DUTY, 16'h0000);
               write_csr(CSR_ZERO_BIT_DUTY, 16'hFFFF);
            end
            2: begin
               write_csr(CSR_ONE_BIT_DUTY, 16'hAAAA);
               write_csr(CSR_ZERO_BIT_DUTY, 16'h5555);
            end
            3: begin
               write_csr(CSR_ONE_BIT_DUTY, 16'hFFFF);
               write_csr(CSR_ZERO_BIT_DUTY, 16'hFFFF);
            end
            default: begin
               write_csr(CSR_ONE_BIT_DUTY, DUTY_W'($urandom));
               write_csr(CSR_ZERO_BIT_DUTY, DUTY_W'($urandom));
            end
         endcase
         // The last phase runs at full rate on both sides.
         if (phase == 5)
            quiet = 1'b1;
         queue_random_pixels(35);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
